// ===== hw/rtl/sac4_pkg.sv =====
// shared types and constants for the 4-way set-associative cache
// no dependencies; used by set_assoc_cache_4way
`default_nettype none

package sac4_pkg;

   localparam int WORD_W = 32;
   localparam int AGE_W  = 2;

   localparam logic [AGE_W-1:0] AGE_TOP = 2'd3;

   // access kinds carried on req_tuser
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef logic [WORD_W-1:0] word_type;

endpackage

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_4way.sv =====
// top level of the set-associative write-through cache
// depends on sac4_pkg and sac4_ram
`default_nettype none

// An access is taken in ST_IDLE, where the set's row is read from the row
// ram; in ST_LOOKUP the hit check, victim choice, age update and write-back
// of the whole row happen, which also loads the result register. The next
// item is taken in the cycle after write-back, and no new item is taken
// before the last one is through; a result not taken holds the access in
// ST_LOOKUP. After reset the block clears the row ram one row at a time
// (valid bits and ages to zero) and accepts no item during that time.
// SET_COUNT must be a power of two; address bits [1:0] are ignored, the
// next log2(SET_COUNT) bits pick the set and the rest form the tag. Each
// row holds, per way, a valid bit, a 2-bit age, the tag and one data word.
// Hit and miss counts cover reads only.

module set_assoc_cache_4way #(
   parameter int SET_COUNT = 16,
   parameter int WAY_COUNT = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // address [31:0], write_word [63:32], memory_word [95:64]
   input  wire logic [95:0]  req_tdata,
   // opcode [0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_word [31:0], hits_so_far [63:32], misses_so_far [95:64]
   output logic      [95:0]  rsp_tdata,
   // was_hit [0], memory_write [1]
   output logic      [1:0]   rsp_tuser
);

   import sac4_pkg::*;

   localparam int SET_W  = $clog2(SET_COUNT);
   localparam int WAY_W  = $clog2(WAY_COUNT);
   localparam int TAG_W  = WORD_W - 2 - SET_W;
   localparam int WAYB   = 1 + AGE_W + TAG_W + WORD_W;
   localparam int ROW_W  = WAY_COUNT * WAYB;
   localparam int AGE_LO = 1;
   localparam int TAG_LO = 1 + AGE_W;
   localparam int DAT_LO = 1 + AGE_W + TAG_W;

   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

   state_type state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;

   // captured item
   logic             op_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   word_type         wword_ff;
   word_type         mword_ff;

   logic     rsp_valid_ff, rsp_valid_in;
   word_type rd_word_ff;
   logic     hit_out_ff;
   logic     mwr_ff;
   word_type hit_cnt_ff, hit_cnt_in;
   word_type miss_cnt_ff, miss_cnt_in;

   logic             accept;
   logic             finish;
   logic             ram_we;
   logic [SET_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_new;

   logic             vld   [WAY_COUNT];
   logic [AGE_W-1:0] age   [WAY_COUNT];
   logic [TAG_W-1:0] tagv  [WAY_COUNT];
   word_type         dat   [WAY_COUNT];
   logic             hit;
   logic [WAY_W-1:0] hway;
   logic [WAY_W-1:0] vway;
   logic [WAY_W-1:0] way;
   word_type         rd_word;

   assign accept = req_tvalid && req_tready;

   sac4_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_COUNT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_tdata[2 +: SET_W]),
      .rd_data (row_rd)
   );

   // unpack the row, find the hit, pick the victim, build the new row
   always_comb begin
      for (int w = 0; w < WAY_COUNT; w++) begin
         vld[w]  = row_rd[w*WAYB];
         age[w]  = row_rd[w*WAYB + AGE_LO +: AGE_W];
         tagv[w] = row_rd[w*WAYB + TAG_LO +: TAG_W];
         dat[w]  = row_rd[w*WAYB + DAT_LO +: WORD_W];
      end

      // scan downward so the lowest matching way wins
      hit  = 1'b0;
      hway = '0;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (vld[w] && tagv[w] == tag_ff) begin
            hit  = 1'b1;
            hway = WAY_W'(w);
         end
      end

      // lowest age, ties to the highest way
      vway = '0;
      for (int w = 1; w < WAY_COUNT; w++) begin
         if (age[w] <= age[vway]) begin
            vway = WAY_W'(w);
         end
      end

      way = hit ? hway : vway;

      row_new = row_rd;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (WAY_W'(w) == way) begin
            row_new[w*WAYB]                   = 1'b1;
            row_new[w*WAYB + AGE_LO +: AGE_W] = AGE_TOP;
            row_new[w*WAYB + TAG_LO +: TAG_W] = tag_ff;
            if (op_ff == OP_WRITE) begin
               row_new[w*WAYB + DAT_LO +: WORD_W] = wword_ff;
            end else if (!hit) begin
               row_new[w*WAYB + DAT_LO +: WORD_W] = mword_ff;
            end
         end else if (age[w] != '0) begin
            row_new[w*WAYB + AGE_LO +: AGE_W] = age[w] - AGE_W'(1);
         end
      end

      if (op_ff == OP_WRITE) begin
         rd_word = '0;
      end else if (hit) begin
         rd_word = dat[hway];
      end else begin
         rd_word = mword_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_tready   = 1'b0;
      finish       = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = set_ff;
      ram_wdata    = row_new;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + SET_W'(1);
            if (clr_ff == SET_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // wait here while the previous result is still unclaimed
            if (!rsp_valid_ff || rsp_tready) begin
               finish       = 1'b1;
               ram_we       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_READ) begin
                  if (hit) begin
                     hit_cnt_in = hit_cnt_ff + word_type'(1);
                  end else begin
                     miss_cnt_in = miss_cnt_ff + word_type'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tuser[0];
         set_ff   <= req_tdata[2 +: SET_W];
         tag_ff   <= req_tdata[WORD_W-1 -: TAG_W];
         wword_ff <= req_tdata[WORD_W +: WORD_W];
         mword_ff <= req_tdata[2*WORD_W +: WORD_W];
      end
      if (finish) begin
         rd_word_ff <= rd_word;
         hit_out_ff <= hit;
         mwr_ff     <= (op_ff == OP_WRITE);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {miss_cnt_ff, hit_cnt_ff, rd_word_ff};
   assign rsp_tuser  = {mwr_ff, hit_out_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/sac4_ram.sv =====
// generic single-clock ram, one write port and one read port
// read data is registered; no dependencies
`default_nettype none

module sac4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== verif/cache_checker.sv =====
`timescale 1ns / 100ps
// checker for set_assoc_cache_4way: watches the request and reply streams, keeps
// its own copy of tags, data, ages and read counters, and compares every reply
// depends on sac4_pkg
module cache_checker #(
   parameter int SET_COUNT = 16,
   parameter int WAY_COUNT = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   // address [31:0], write_word [63:32], memory_word [95:64]
   input  wire logic [95:0]  req_tdata,
   // opcode [0]
   input  wire logic [0:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_word [31:0], hits_so_far [63:32], misses_so_far [95:64]
   input  wire logic [95:0]  rsp_tdata,
   // was_hit [0], memory_write [1]
   input  wire logic [1:0]   rsp_tuser,
   output int                failures,
   output int                replies_waiting
);

   import sac4_pkg::*;

   localparam int SET_BITS = $clog2(SET_COUNT);
   localparam int TAG_W    = WORD_W - 2 - SET_BITS;
   localparam int LINES    = SET_COUNT * WAY_COUNT;

   typedef struct packed {
      word_type read_word;
      logic     was_hit;
      logic     memory_write;
      word_type hits_so_far;
      word_type misses_so_far;
   } cache_reply_type;

   logic [TAG_W-1:0] way_tag   [LINES];
   logic             way_valid [LINES];
   word_type         way_data  [LINES];
   logic [AGE_W-1:0] way_age   [LINES];
   word_type         hit_count;
   word_type         miss_count;
   cache_reply_type  awaited_replies [$];
   int               errors = 0;

   // the touched way becomes youngest, every other nonzero age steps down
   function automatic void make_youngest(int base, int way);
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (w != way && way_age[base + w] != '0) begin
            way_age[base + w] = way_age[base + w] - AGE_W'(1);
         end
      end
      way_age[base + way] = AGE_TOP;
   endfunction

   function automatic cache_reply_type cache_access(logic op, word_type addr,
                                                   word_type wword, word_type mword);
      cache_reply_type  reply;
      int               base;
      int               way;
      logic [TAG_W-1:0] tag;
      logic             hit;
      base = int'(addr[SET_BITS+1:2]) * WAY_COUNT;
      tag  = addr[WORD_W-1:SET_BITS+2];
      hit  = 1'b0;
      way  = 0;
      // scan downward so that the lowest matching way is the one kept
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (way_valid[base + w] && way_tag[base + w] == tag) begin
            hit = 1'b1;
            way = w;
         end
      end
      if (!hit) begin
         // invalid ways compete on age like any other; ties go upward
         way = 0;
         for (int w = 1; w < WAY_COUNT; w++) begin
            if (way_age[base + w] <= way_age[base + way]) begin
               way = w;
            end
         end
         way_tag[base + way]   = tag;
         way_valid[base + way] = 1'b1;
         way_data[base + way]  = (op == OP_WRITE) ? wword : mword;
      end else if (op == OP_WRITE) begin
         way_data[base + way] = wword;
      end
      make_youngest(base, way);
      reply.read_word = '0;
      if (op != OP_WRITE) begin
         reply.read_word = way_data[base + way];
         if (hit) begin
            hit_count = hit_count + word_type'(1);
         end else begin
            miss_count = miss_count + word_type'(1);
         end
      end
      reply.was_hit       = hit;
      reply.memory_write  = (op == OP_WRITE);
      reply.hits_so_far   = hit_count;
      reply.misses_so_far = miss_count;
      return reply;
   endfunction

   task automatic check_field(string name, word_type want, word_type got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch_streams
      cache_reply_type want;
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            way_valid[i] = 1'b0;
            way_age[i]   = '0;
         end
         hit_count  = '0;
         miss_count = '0;
         awaited_replies.delete();
      end else begin
         // a reply never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_replies.size() == 0) begin
               $display("%0t: reply expected none actual tdata %h tuser %h",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("read_word", want.read_word, rsp_tdata[31:0]);
               check_field("was_hit", word_type'(want.was_hit),
                           word_type'(rsp_tuser[0]));
               check_field("memory_write", word_type'(want.memory_write),
                           word_type'(rsp_tuser[1]));
               check_field("hits_so_far", want.hits_so_far, rsp_tdata[63:32]);
               check_field("misses_so_far", want.misses_so_far, rsp_tdata[95:64]);
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_replies.push_back(cache_access(req_tuser[0], req_tdata[31:0],
                                                   req_tdata[63:32], req_tdata[95:64]));
         end
      end
      failures        <= errors;
      replies_waiting <= awaited_replies.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// top of the set_assoc_cache_4way testbench: clock, reset, access stimulus,
// idling on both streams, watchdog and verdict; depends on sac4_pkg and cache_checker
module testbench;
   import sac4_pkg::*;

   localparam int SET_COUNT       = 16;
   localparam int WAY_COUNT       = 4;
   localparam int SET_BITS        = $clog2(SET_COUNT);
   localparam int TAG_W           = WORD_W - 2 - SET_BITS;
   localparam int RANDOM_ACCESSES = 1130;
   localparam int POOL_SIZE       = 5;
   localparam int STALL_LIMIT     = 3000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int failures;
   int replies_waiting;
   int quiet_cycles = 0;
   int calm_items   = 0;
   int stall_left   = 0;
   int steady_left  = 0;

   logic [TAG_W-1:0] tag_pool [POOL_SIZE];

   always #5 clock = ~clock;

   set_assoc_cache_4way #(
      .SET_COUNT(SET_COUNT),
      .WAY_COUNT(WAY_COUNT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   cache_checker #(
      .SET_COUNT(SET_COUNT),
      .WAY_COUNT(WAY_COUNT)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .failures       (failures),
      .replies_waiting(replies_waiting)
   );

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   function automatic word_type make_address(logic [TAG_W-1:0] tag,
                                             logic [SET_BITS-1:0] set, logic [1:0] low);
      return {tag, set, low};
   endfunction

   task automatic put_access(logic op, word_type addr, word_type wword, word_type mword);
      int gap;
      if (calm_items > 0) begin
         gap = 0;
         calm_items--;
      end else begin
         gap = idle_length();
         if ($urandom_range(99) < 3) calm_items = $urandom_range(60, 20);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {mword, wword, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // reply side: random stalls with stretches of steady ready
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (steady_left > 0) begin
            steady_left <= steady_left - 1;
         end else if ($urandom_range(99) < 2) begin
            steady_left <= $urandom_range(80, 30);
         end else begin
            stall_left <= idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      word_type addr;
      logic     op;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cold miss on an empty set: the tie goes to the top way
      put_access(OP_READ, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      // byte offset bits are ignored
      put_access(OP_READ, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0000);
      put_access(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
      put_access(OP_READ, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
      put_access(OP_WRITE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      // write miss allocates; top set, all-ones tag
      put_access(OP_WRITE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
      put_access(OP_READ, 32'hFFFF_FFFC, 32'h0000_0000, 32'h5A5A_5A5A);
      // fill one set past its ways so the oldest line gets evicted
      for (int t = 1; t <= 5; t++) begin
         put_access(OP_READ, make_address(TAG_W'(t), SET_BITS'(5), 2'd0), $urandom, $urandom);
      end
      put_access(OP_READ, make_address(TAG_W'(1), SET_BITS'(5), 2'd0), $urandom, $urandom);
      put_access(OP_READ, make_address(TAG_W'(5), SET_BITS'(5), 2'd2), $urandom, $urandom);
      put_access(OP_WRITE, make_address(TAG_W'(7), SET_BITS'(5), 2'd1), $urandom, $urandom);
      put_access(OP_READ, make_address(TAG_W'(7), SET_BITS'(5), 2'd0), $urandom, $urandom);
      put_access(OP_WRITE, make_address(TAG_W'(4), SET_BITS'(5), 2'd3), $urandom, $urandom);
      put_access(OP_READ, make_address(TAG_W'(0), SET_BITS'(5), 2'd0), $urandom, $urandom);
      put_access(OP_READ, make_address(TAG_W'(4), SET_BITS'(5), 2'd0), $urandom, $urandom);

      // a small tag pool per phase keeps sets busy with hits and evictions
      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n % 250 == 0) begin
            foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
         end
         if ($urandom_range(99) < 85) begin
            addr = make_address(tag_pool[$urandom_range(POOL_SIZE - 1)],
                                SET_BITS'($urandom), 2'($urandom));
         end else begin
            addr = $urandom;
         end
         op = ($urandom_range(99) < 35) ? OP_WRITE : OP_READ;
         put_access(op, addr, $urandom, $urandom);
      end
      req_tvalid <= 1'b0;

      // let the checker count the last item before waiting on its reply
      @(posedge clock);
      while (replies_waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && replies_waiting == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
